// ===== design/aim_pkg.sv =====
// aim_pkg: shared types and constants for the aim angle and muzzle point block
// holds payload structs, pipeline structs, the cordic angle table and fixed-point constants
// no dependencies
package aim_pkg;

  localparam int COORD_W    = 16;
  localparam int BEARING_W  = 15;
  localparam int OFFSET_W   = 15;
  localparam int VEC_W      = 44;   // vectoring datapath, 24 fractional bits
  localparam int ROT_W      = 48;   // rotation datapath, 30 fractional bits
  localparam int ANG_W      = 30;   // angle in units of 2^-20 degree
  localparam int VEC_SHIFT  = 24;
  localparam int ROT_SHIFT  = 30;
  localparam int BEAR_SHIFT = 14;
  localparam int TABLE_LEN  = 24;

  localparam logic [29:0] KINV_Q30 = 30'd652032875;

  localparam logic signed [ANG_W-1:0] HALF_TURN_Z = ANG_W'(180 << 20);
  localparam logic signed [ANG_W-1:0] QUARTER_Z   = ANG_W'(90 << 20);
  localparam logic signed [17:0]      BEARING_MOD = 18'sd23040;
  localparam logic [BEARING_W-1:0]    HALF_MOD    = 15'd11520;

  // atan(2^-i) in degrees, units of 2^-20 degree
  localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
    30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
    30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
    30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
    30'sd917,      30'sd458,      30'sd229,      30'sd115,
    30'sd57,       30'sd29,       30'sd14,       30'sd7
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] self_x;
    logic signed [COORD_W-1:0] self_y;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
  } aim_req_t;

  typedef struct packed {
    logic [BEARING_W-1:0]      bearing;
    logic signed [COORD_W-1:0] muzzle_x;
    logic signed [COORD_W-1:0] muzzle_y;
    logic                      coincident;
  } aim_res_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } rot_t;

  // values that ride alongside the cordic data
  typedef struct packed {
    logic signed [COORD_W-1:0] self_x;
    logic signed [COORD_W-1:0] self_y;
    logic [BEARING_W-1:0]      bearing;
    logic                      coincident;
    logic                      neg;
  } side_t;

endpackage

// ===== design/aim_vec_cell.sv =====
// aim_vec_cell: one vectoring cordic micro-rotation, registered
// drives y toward zero and accumulates the angle; depends on aim_pkg
module aim_vec_cell import aim_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  input  vec_t  up_vec,
  input  side_t up_side,
  output logic  dn_valid,
  output vec_t  dn_vec,
  output side_t dn_side
);

  localparam logic signed [ANG_W-1:0] STEP = ATAN_TAB[STAGE];

  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;
  vec_t                    vec_next;

  assign xs = $signed(up_vec.x) >>> STAGE;
  assign ys = $signed(up_vec.y) >>> STAGE;

  always_comb begin
    if (!up_vec.y[VEC_W-1]) begin
      vec_next.x = up_vec.x + ys;
      vec_next.y = up_vec.y - xs;
      vec_next.z = up_vec.z + STEP;
    end else begin
      vec_next.x = up_vec.x - ys;
      vec_next.y = up_vec.y + xs;
      vec_next.z = up_vec.z - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else begin
      dn_valid <= up_valid;
    end
    dn_vec  <= vec_next;
    dn_side <= up_side;
  end

endmodule

// ===== design/aim_rot_cell.sv =====
// aim_rot_cell: one rotation cordic micro-rotation, registered
// turns the offset vector until the residual angle reaches zero; depends on aim_pkg
module aim_rot_cell import aim_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  input  rot_t  up_rot,
  input  side_t up_side,
  output logic  dn_valid,
  output rot_t  dn_rot,
  output side_t dn_side
);

  localparam logic signed [ANG_W-1:0] STEP = ATAN_TAB[STAGE];

  logic signed [ROT_W-1:0] xs;
  logic signed [ROT_W-1:0] ys;
  rot_t                    rot_next;

  assign xs = $signed(up_rot.x) >>> STAGE;
  assign ys = $signed(up_rot.y) >>> STAGE;

  always_comb begin
    if (!up_rot.z[ANG_W-1]) begin
      rot_next.x = up_rot.x - ys;
      rot_next.y = up_rot.y + xs;
      rot_next.z = up_rot.z - STEP;
    end else begin
      rot_next.x = up_rot.x + ys;
      rot_next.y = up_rot.y - xs;
      rot_next.z = up_rot.z + STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else begin
      dn_valid <= up_valid;
    end
    dn_rot  <= rot_next;
    dn_side <= up_side;
  end

endmodule

// ===== design/aim_angle_and_muzzle_point.sv =====
// aim_angle_and_muzzle_point: bearing from shooter to target and muzzle point on it
// top level; depends on aim_pkg, aim_vec_cell and aim_rot_cell
//
//   port       dir  width  meaning
//   start      in   1      request strobe, taken when busy is low
//   busy       out  1      high in reset and the cycle after it
//   req        in   64     aim_req_t: shooter and target positions
//   done       out  1      result strobe, one cycle per transaction
//   result     out  48     aim_res_t: bearing, muzzle point, coincident flag
//   cfg_valid  in   1      muzzle offset write
//   cfg_ready  out  1      write taken when valid and ready are high
//   cfg_data   in   15     muzzle offset, unsigned q15.0
//
// one transaction per cycle while busy is low; a request passes through an input
// register, CORDIC_STAGES vectoring cells, a bearing and rotation setup register,
// CORDIC_STAGES rotation cells and an output register that drives done and result.
// synchronous reset clears all valid bits and the offset register.
// nothing stalls: the receiver must take done on the cycle it is shown.
module aim_angle_and_muzzle_point import aim_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  aim_req_t            req,
  output logic                done,
  output aim_res_t            result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [OFFSET_W-1:0] cfg_data
);

  localparam int LATENCY = 2 * CORDIC_STAGES + 3;

  logic                boot;
  logic [OFFSET_W-1:0] muzzle_offset;
  logic                accept;

  vec_t  vec_pipe  [CORDIC_STAGES+1];
  side_t vec_side  [CORDIC_STAGES+1];
  logic  vec_valid [CORDIC_STAGES+1];
  rot_t  rot_pipe  [CORDIC_STAGES+1];
  side_t rot_side  [CORDIC_STAGES+1];
  logic  rot_valid [CORDIC_STAGES+1];

  assign busy      = rst | boot;
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      boot          <= 1'b1;
      muzzle_offset <= '0;
    end else begin
      boot <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        muzzle_offset <= cfg_data;
      end
    end
  end

  // input stage: differences, half-plane fold, prescale
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic signed [17:0] dxa;
  logic signed [17:0] dya;
  vec_t               vec_init;
  side_t              side_init;

  always_comb begin
    dx  = {{2{req.target_x[COORD_W-1]}}, req.target_x} - {{2{req.self_x[COORD_W-1]}}, req.self_x};
    dy  = {{2{req.target_y[COORD_W-1]}}, req.target_y} - {{2{req.self_y[COORD_W-1]}}, req.self_y};
    dxa = dx[17] ? -dx : dx;
    dya = dx[17] ? -dy : dy;
    vec_init.x = VEC_W'(dxa) <<< VEC_SHIFT;
    vec_init.y = VEC_W'(dya) <<< VEC_SHIFT;
    vec_init.z = dx[17] ? HALF_TURN_Z : '0;
    side_init.self_x     = req.self_x;
    side_init.self_y     = req.self_y;
    side_init.bearing    = '0;
    side_init.coincident = (dx == '0) && (dy == '0);
    side_init.neg        = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_valid[0] <= 1'b0;
    end else begin
      vec_valid[0] <= accept;
    end
    vec_pipe[0] <= vec_init;
    vec_side[0] <= side_init;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_vec
      aim_vec_cell #(.STAGE(gi)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .up_valid (vec_valid[gi]),
        .up_vec   (vec_pipe[gi]),
        .up_side  (vec_side[gi]),
        .dn_valid (vec_valid[gi+1]),
        .dn_vec   (vec_pipe[gi+1]),
        .dn_side  (vec_side[gi+1])
      );
    end
  endgenerate

  // bearing rounding and wrap, then rotation setup
  logic signed [ANG_W:0]     z_round;
  logic signed [16:0]        b_raw;
  logic signed [17:0]        b_wrap;
  logic [BEARING_W-1:0]      bearing;
  logic [BEARING_W-1:0]      t_red;
  logic                      neg;
  logic [OFFSET_W+29:0]      offset_scaled;
  rot_t                      rot_init;
  side_t                     rot_side_init;

  always_comb begin
    z_round = {vec_pipe[CORDIC_STAGES].z[ANG_W-1], vec_pipe[CORDIC_STAGES].z}
              + (ANG_W+1)'(1 << (BEAR_SHIFT - 1));
    b_raw   = z_round[ANG_W:BEAR_SHIFT];
    if (b_raw[16]) begin
      b_wrap = 18'(b_raw) + BEARING_MOD;
    end else if (18'(b_raw) >= BEARING_MOD) begin
      b_wrap = 18'(b_raw) - BEARING_MOD;
    end else begin
      b_wrap = 18'(b_raw);
    end
    bearing = vec_side[CORDIC_STAGES].coincident ? '0 : b_wrap[BEARING_W-1:0];
    neg     = (bearing >= HALF_MOD);
    t_red   = neg ? bearing - HALF_MOD : bearing;
    offset_scaled = muzzle_offset * KINV_Q30;
    rot_init.x = '0;
    rot_init.y = ROT_W'(offset_scaled);
    rot_init.z = $signed(ANG_W'({t_red, {BEAR_SHIFT{1'b0}}})) - QUARTER_Z;
    rot_side_init            = vec_side[CORDIC_STAGES];
    rot_side_init.bearing    = bearing;
    rot_side_init.neg        = neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid[0] <= 1'b0;
    end else begin
      rot_valid[0] <= vec_valid[CORDIC_STAGES];
    end
    rot_pipe[0] <= rot_init;
    rot_side[0] <= rot_side_init;
  end

  generate
    for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_rot
      aim_rot_cell #(.STAGE(gi)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .up_valid (rot_valid[gi]),
        .up_rot   (rot_pipe[gi]),
        .up_side  (rot_side[gi]),
        .dn_valid (rot_valid[gi+1]),
        .dn_rot   (rot_pipe[gi+1]),
        .dn_side  (rot_side[gi+1])
      );
    end
  endgenerate

  // output stage: undo the half-turn fold, round, add to shooter, saturate
  logic signed [ROT_W-1:0] ox_full;
  logic signed [ROT_W-1:0] oy_full;
  logic signed [ROT_W-1:0] ox_round;
  logic signed [ROT_W-1:0] oy_round;
  logic signed [18:0]      mx;
  logic signed [18:0]      my;
  aim_res_t                result_next;

  always_comb begin
    ox_full  = rot_side[CORDIC_STAGES].neg ? -rot_pipe[CORDIC_STAGES].x
                                           : rot_pipe[CORDIC_STAGES].x;
    oy_full  = rot_side[CORDIC_STAGES].neg ? -rot_pipe[CORDIC_STAGES].y
                                           : rot_pipe[CORDIC_STAGES].y;
    ox_round = ox_full + ROT_W'(64'd1 << (ROT_SHIFT - 1));
    oy_round = oy_full + ROT_W'(64'd1 << (ROT_SHIFT - 1));
    mx = 19'(rot_side[CORDIC_STAGES].self_x) + 19'($signed(ox_round[ROT_W-1:ROT_SHIFT]));
    my = 19'(rot_side[CORDIC_STAGES].self_y) + 19'($signed(oy_round[ROT_W-1:ROT_SHIFT]));
    result_next.bearing    = rot_side[CORDIC_STAGES].bearing;
    result_next.coincident = rot_side[CORDIC_STAGES].coincident;
    if (mx > 19'sd32767) begin
      result_next.muzzle_x = 16'sh7fff;
    end else if (mx < -19'sd32768) begin
      result_next.muzzle_x = 16'sh8000;
    end else begin
      result_next.muzzle_x = mx[15:0];
    end
    if (my > 19'sd32767) begin
      result_next.muzzle_y = 16'sh7fff;
    end else if (my < -19'sd32768) begin
      result_next.muzzle_y = 16'sh8000;
    end else begin
      result_next.muzzle_y = my[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rot_valid[CORDIC_STAGES];
    end
    result <= result_next;
  end

`ifndef ASSERT_OFF
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result missing after fixed pipeline latency");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without a matching request");

  a_bearing_range : assert property (@(posedge clk) disable iff (rst)
    done |-> result.bearing < 15'd23040)
    else $error("bearing outside a full turn");

  a_coincident_zero : assert property (@(posedge clk) disable iff (rst)
    done && result.coincident |-> result.bearing == '0)
    else $error("coincident positions with non-zero bearing");
`endif

endmodule

// ===== tb/sv/aim_angle_and_muzzle_point_tb.sv =====
// aim_angle_and_muzzle_point_tb: self-checking bench for the bearing and muzzle point block
// drives requests and offset writes, predicts each result with a cordic model of its own
// depends on aim_pkg and aim_angle_and_muzzle_point
module aim_angle_and_muzzle_point_tb;
  import aim_pkg::*;

  localparam int     STAGES       = 16;
  localparam int     LATENCY      = 2 * STAGES + 3;
  localparam int     CYCLE_LIMIT  = 100000;
  localparam int     PHASES       = 8;
  localparam int     PHASE_ITEMS  = 141;
  localparam longint FULL_TURN_Q6 = 23040;
  localparam longint HALF_TURN_Q6 = 11520;

  class aim_scoreboard;
    aim_res_t    pending_aims[$];
    bit [14:0]   muzzle_offset = '0;
    int          errors = 0;
    int          checked = 0;
    int          coincident_seen = 0;
    int          saturated_seen = 0;

    function longint clamp_coord(longint v);
      if (v > 32767) begin
        saturated_seen++;
        return 32767;
      end
      if (v < -32768) begin
        saturated_seen++;
        return -32768;
      end
      return v;
    endfunction

    // bearing by vectoring cordic, then the offset turned onto that bearing
    task predict_aim(aim_req_t r);
      longint   sx, sy, dx, dy, x, y, z, xs, ys, bear, t, ox, oy;
      int       n;
      bit       flip;
      aim_res_t want;
      n  = (STAGES > TABLE_LEN) ? TABLE_LEN : STAGES;
      sx = $signed(r.self_x);
      sy = $signed(r.self_y);
      dx = longint'($signed(r.target_x)) - sx;
      dy = longint'($signed(r.target_y)) - sy;
      want.coincident = (dx == 0 && dy == 0);
      bear = 0;
      if (!want.coincident) begin
        x = dx;
        y = dy;
        z = 0;
        // left half plane: mirror through the origin and start from a half turn
        if (x < 0) begin
          x = -x;
          y = -y;
          z = longint'(180) << 20;
        end
        x = x * (longint'(1) << VEC_SHIFT);
        y = y * (longint'(1) << VEC_SHIFT);
        for (int i = 0; i < n; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(ATAN_TAB[i]);
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(ATAN_TAB[i]);
          end
        end
        bear = (z + (longint'(1) << (BEAR_SHIFT - 1))) >>> BEAR_SHIFT;
        while (bear < 0) bear = bear + FULL_TURN_Q6;
        while (bear >= FULL_TURN_Q6) bear = bear - FULL_TURN_Q6;
      end else begin
        coincident_seen++;
      end
      t    = bear;
      flip = 1'b0;
      if (t >= HALF_TURN_Q6) begin
        t    = t - HALF_TURN_Q6;
        flip = 1'b1;
      end
      x = 0;
      y = longint'(muzzle_offset) * longint'(KINV_Q30);
      z = t * (longint'(1) << BEAR_SHIFT) - (longint'(90) << 20);
      for (int i = 0; i < n; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(ATAN_TAB[i]);
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(ATAN_TAB[i]);
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      ox = (x + (longint'(1) << (ROT_SHIFT - 1))) >>> ROT_SHIFT;
      oy = (y + (longint'(1) << (ROT_SHIFT - 1))) >>> ROT_SHIFT;
      want.bearing  = 15'(bear);
      want.muzzle_x = 16'(clamp_coord(sx + ox));
      want.muzzle_y = 16'(clamp_coord(sy + oy));
      pending_aims.push_back(want);
    endtask

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_aim(aim_res_t got);
      aim_res_t want;
      if (pending_aims.size() == 0) begin
        report_mismatch($sformatf("result %h with no request outstanding", got));
        return;
      end
      want = pending_aims.pop_front();
      checked++;
      if (got.bearing !== want.bearing)
        report_mismatch($sformatf("result %0d bearing %0d, predicted %0d",
                                  checked, got.bearing, want.bearing));
      if (got.muzzle_x !== want.muzzle_x)
        report_mismatch($sformatf("result %0d muzzle_x %0d, predicted %0d",
                                  checked, got.muzzle_x, want.muzzle_x));
      if (got.muzzle_y !== want.muzzle_y)
        report_mismatch($sformatf("result %0d muzzle_y %0d, predicted %0d",
                                  checked, got.muzzle_y, want.muzzle_y));
      if (got.coincident !== want.coincident)
        report_mismatch($sformatf("result %0d coincident %0b, predicted %0b",
                                  checked, got.coincident, want.coincident));
    endtask
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  aim_req_t            req = '0;
  logic                done;
  aim_res_t            result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [OFFSET_W-1:0] cfg_data = '0;

  aim_scoreboard sb = new();
  int            cycle_count = 0;
  int            offset_settings = 0;

  aim_angle_and_muzzle_point #(.CORDIC_STAGES(STAGES)) uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // requests and results are both seen on pre-edge values
  always @(posedge clk) begin
    if (start && !busy) sb.predict_aim(req);
    if (!rst && done) sb.check_aim(result);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending_aims.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task send_aim(aim_req_t r);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task send_xy(int sx, int sy, int tx, int ty);
    aim_req_t r;
    r.self_x   = 16'(sx);
    r.self_y   = 16'(sy);
    r.target_x = 16'(tx);
    r.target_y = 16'(ty);
    send_aim(r);
  endtask

  task hold_off(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_aims.size() != 0) @(posedge clk);
  endtask

  // waits for the pipeline to drain before the write
  task write_muzzle_offset(bit [14:0] v);
    wait_for_results();
    repeat (LATENCY) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.muzzle_offset = v;
    offset_settings++;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit [14:0] phase_offsets [PHASES];
    aim_req_t  r;
    bit        idling;
    int        kind;
    int        edges [4];

    edges = '{-32768, 32767, -32767, 32766};
    phase_offsets = '{15'd0, 15'd1, 15'd32767, 15'($urandom), 15'd16384,
                      15'($urandom), 15'($urandom_range(0, 255)), 15'd32767};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // offset still at its reset value
    send_xy(0, 0, 0, 0);
    send_xy(16, 16, -16, -16);
    send_xy(-32768, 0, 32767, 0);
    send_xy(123, -456, -789, 1011);

    write_muzzle_offset(15'd32767);
    send_xy(0, 0, 0, 0);
    send_xy(32767, 32767, 32767, 32767);
    send_xy(-32768, -32768, -32768, -32768);
    send_xy(-32768, -32768, 32767, 32767);
    send_xy(32767, 32767, -32768, -32768);
    send_xy(-32768, 32767, 32767, -32768);
    send_xy(32767, -32768, -32768, 32767);
    send_xy(0, 0, 100, 0);
    send_xy(0, 0, -100, 0);
    send_xy(0, 0, 0, 100);
    send_xy(0, 0, 0, -100);
    send_xy(0, 0, 1, 0);
    send_xy(0, 0, -1, -1);
    // just below a full turn, rounds onto the wrap
    send_xy(0, 0, 32767, -1);
    send_xy(0, 0, -32768, 1);
    send_xy(0, 0, -32768, -1);
    send_xy(5, -7, 5, -8);
    send_xy(1000, 2000, 1001, 2003);

    for (int p = 0; p < PHASES; p++) begin
      write_muzzle_offset(phase_offsets[p]);
      idling = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 32 == 0) idling = (p != PHASES - 1) && $urandom_range(0, 1);
        kind       = $urandom_range(0, 9);
        r.self_x   = 16'($urandom);
        r.self_y   = 16'($urandom);
        r.target_x = 16'($urandom);
        r.target_y = 16'($urandom);
        case (kind)
          5, 6: begin
            r.target_x = r.self_x + 16'($urandom_range(0, 128) - 64);
            r.target_y = r.self_y + 16'($urandom_range(0, 128) - 64);
          end
          7: begin
            r.target_x = r.self_x;
            r.target_y = r.self_y;
          end
          8: begin
            if ($urandom_range(0, 1)) r.target_x = r.self_x;
            else r.target_y = r.self_y;
          end
          9: begin
            r.self_x = 16'(edges[$urandom_range(0, 3)]);
            r.self_y = 16'(edges[$urandom_range(0, 3)]);
          end
          default: ;
        endcase
        send_aim(r);
        if (p % 2 == 1 && i == PHASE_ITEMS / 2) wait_for_results();
        else if (idling && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 12));
      end
    end

    wait_for_results();
    repeat (LATENCY + 4) @(posedge clk);

    $display("covered %0d aim requests over %0d muzzle offset settings", sb.checked,
             offset_settings);
    $display("%0d coincident pairs, %0d saturated muzzle coordinates, %0d mismatches",
             sb.coincident_seen, sb.saturated_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/aim_pkg.sv
design/aim_vec_cell.sv
design/aim_rot_cell.sv
design/aim_angle_and_muzzle_point.sv
tb/sv/aim_angle_and_muzzle_point_tb.sv
